// ===== rtl/core/paq_pkg.sv =====
// Shared types, widths and helpers for the per-row absmax int8 quantizer.
// No dependencies; every other file of the block uses this package.
package paq_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_COLS     = 64;
    localparam int COL_W        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W        = $clog2(MAX_COLS + 1);
    localparam int MAG_W        = SAMPLE_WIDTH + 1;
    localparam int QUANT_W      = 8;
    localparam int QUO_W        = QUANT_W - 1;
    localparam int NUM_W        = MAG_W + 8;
    localparam int DEN_W        = MAG_W + 1;
    localparam int SCALE_W      = 25;
    localparam int Z_W          = MAG_W + 2;
    localparam int Q0_W         = Z_W - 6;
    // integer part of 2^16 / 127
    localparam int SCALE_INT    = 516;
    localparam int QUANT_MAX    = 127;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // read request toward the row buffer and quantizer pipe
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic             last;
    } t_rd_req;

    // tag that travels with an item through the divider stages
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [COL_W-1:0] col;
        logic             last;
    } t_tag;

    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_WIDTH-1:0] raw);
        logic [MAG_W-1:0] ext;
        ext = {raw[SAMPLE_WIDTH-1], raw};
        if (raw[SAMPLE_WIDTH-1]) begin
            return MAG_W'(0) - ext;
        end
        return ext;
    endfunction

endpackage

// ===== rtl/core/paq_row_ram.sv =====
// Row buffer: one-write, one-read synchronous memory with registered read data.
// Depends on paq_pkg for depth and sample width.
module paq_row_ram (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [paq_pkg::COL_W-1:0]        i_waddr,
    input  logic [paq_pkg::SAMPLE_WIDTH-1:0] i_wdata,
    input  logic                             i_re,
    input  logic [paq_pkg::COL_W-1:0]        i_raddr,
    output logic [paq_pkg::SAMPLE_WIDTH-1:0] o_rdata
);
    import paq_pkg::*;

    logic [SAMPLE_WIDTH-1:0] mem [MAX_COLS];
    logic [SAMPLE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/paq_scale.sv =====
// Row scale: round(absmax * 2^16 / 127) in two registered steps.
// Uses 516*a + floor((4a + 63) / 127), the quotient by reciprocal plus one fix-up.
// Depends on paq_pkg.
module paq_scale (
    input  logic                        i_clk,
    input  logic [paq_pkg::MAG_W-1:0]   i_amax,
    output logic [paq_pkg::SCALE_W-1:0] o_scale
);
    import paq_pkg::*;

    logic [Z_W-1:0]      n_z;
    logic [Z_W+9:0]      n_prod;
    logic [Z_W-1:0]      r_z;
    logic [Q0_W-1:0]     r_q0;
    logic [MAG_W+9:0]    r_base;
    logic [Z_W:0]        rem;
    logic [Q0_W-1:0]     quo;
    logic [SCALE_W-1:0]  r_scale;

    always_comb begin
        n_z    = {i_amax, 2'b00} + Z_W'(63);
        n_prod = (Z_W+10)'(n_z) * (Z_W+10)'(SCALE_INT);
    end

    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_q0   <= n_prod[16 +: Q0_W];
        r_base <= (MAG_W+10)'(i_amax) * (MAG_W+10)'(SCALE_INT);
    end

    // reciprocal estimate is at most one low; correct it
    always_comb begin
        rem = (Z_W+1)'(r_z) - (((Z_W+1)'(r_q0) << 7) - (Z_W+1)'(r_q0));
        quo = (rem >= (Z_W+1)'(QUANT_MAX)) ? r_q0 + Q0_W'(1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        r_scale <= SCALE_W'(r_base + (MAG_W+10)'(quo));
    end

    assign o_scale = r_scale;

endmodule

// ===== rtl/core/paq_quant_pipe.sv =====
// Quantizer pipe: buffer read stage, numerator stage and a restoring divider of
// one quotient bit per stage. Depends on paq_pkg; the whole pipe moves on i_advance.
module paq_quant_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  paq_pkg::t_rd_req                    i_req,
    input  logic [paq_pkg::SAMPLE_WIDTH-1:0]    i_rdata,
    input  logic [paq_pkg::MAG_W-1:0]           i_amax,
    output logic                                o_valid,
    output logic signed [paq_pkg::QUANT_W-1:0]  o_quant,
    output logic [paq_pkg::COL_W-1:0]           o_col,
    output logic                                o_last
);
    import paq_pkg::*;

    t_rd_req           r_rd_tag;
    t_tag              r_num_tag;
    logic [NUM_W-1:0]  r_num;
    t_tag              r_tag [QUO_W];
    logic [NUM_W-1:0]  r_rem [QUO_W];
    logic [QUO_W-1:0]  r_quo [QUO_W];

    logic [MAG_W-1:0]  rd_mag;
    logic [NUM_W-1:0]  n_num;
    logic [NUM_W-1:0]  den;
    logic [NUM_W-1:0]  n_rem [QUO_W];
    logic [QUO_W-1:0]  n_quo [QUO_W];
    logic [QUO_W-1:0]  q_out;

    // numerator 254*mag + amax over denominator 2*amax gives round-half-away
    always_comb begin
        rd_mag = magnitude(i_rdata);
        n_num  = (NUM_W'(rd_mag) << 8) - (NUM_W'(rd_mag) << 1) + NUM_W'(i_amax);
        den    = NUM_W'({i_amax, 1'b0});
    end

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            logic [NUM_W-1:0] src_rem;
            logic [QUO_W-1:0] src_quo;
            logic [NUM_W-1:0] sub;
            src_rem = (k == 0) ? r_num : r_rem[(k == 0) ? 0 : k - 1];
            src_quo = (k == 0) ? '0 : r_quo[(k == 0) ? 0 : k - 1];
            sub     = den << (QUO_W - 1 - k);
            if (src_rem >= sub) begin
                n_rem[k] = src_rem - sub;
                n_quo[k] = src_quo | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
                n_rem[k] = src_rem;
                n_quo[k] = src_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag  <= '0;
            r_num_tag <= '0;
            for (int k = 0; k < QUO_W; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_advance) begin
            r_rd_tag        <= i_req;
            r_num_tag.valid <= r_rd_tag.valid;
            r_num_tag.neg   <= i_rdata[SAMPLE_WIDTH-1];
            r_num_tag.col   <= r_rd_tag.col;
            r_num_tag.last  <= r_rd_tag.last;
            r_tag[0]        <= r_num_tag;
            for (int k = 1; k < QUO_W; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_num <= n_num;
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    // quotient never exceeds 127 since every magnitude is at most absmax
    assign q_out   = r_quo[QUO_W-1];
    assign o_valid = r_tag[QUO_W-1].valid;
    assign o_col   = r_tag[QUO_W-1].col;
    assign o_last  = r_tag[QUO_W-1].last;
    assign o_quant = r_tag[QUO_W-1].neg ? QUANT_W'(0) - {1'b0, q_out} : {1'b0, q_out};

endmodule

// ===== rtl/core/per_row_absmax_int8_quantizer.sv =====
// Top level of the per-row absmax int8 quantizer: row control, absmax tracking.
// Depends on paq_pkg, paq_row_ram, paq_scale and paq_quant_pipe.
//
//   channel  | valid   | stall   | payload
//   ---------+---------+---------+--------------------------------------------------
//   input    | i_valid | o_stall | i_sample, i_last_in_row
//   output   | o_valid | i_stall | o_quant_value, o_row_scale, o_column, o_last_of_row
//
// A row of N samples is taken one item per cycle into the row buffer.
// When the row closes the block stalls its input and drains: each sample passes the
// buffer read, the numerator stage, the 7-stage divider and the output register,
// and results leave one per cycle while the output is not stalled. Output stall
// freezes the drain; the input opens again once the last result of the row is taken.
// Reset is synchronous and clears control only; the row buffer is not cleared.
module per_row_absmax_int8_quantizer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic signed [paq_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic                                    i_last_in_row,
    output logic                                    o_stall,
    output logic                                    o_valid,
    output logic signed [paq_pkg::QUANT_W-1:0]      o_quant_value,
    output logic [paq_pkg::SCALE_W-1:0]             o_row_scale,
    output logic [paq_pkg::COL_W-1:0]               o_column,
    output logic                                    o_last_of_row,
    input  logic                                    i_stall
);
    import paq_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          r_row_len;
    logic [CNT_W-1:0]          r_rd_cnt;
    logic [MAG_W-1:0]          r_absmax;
    logic [MAG_W-1:0]          r_amax;
    logic                      r_out_valid;
    logic signed [QUANT_W-1:0] r_out_quant;
    logic [SCALE_W-1:0]        r_out_scale;
    logic [COL_W-1:0]          r_out_col;
    logic                      r_out_last;

    logic                      fill_en;
    logic                      drain_en;
    logic                      in_acc;
    logic                      row_close;
    logic                      advance;
    logic                      out_done;
    logic [MAG_W-1:0]          sample_mag;
    logic [MAG_W-1:0]          run_max;
    logic [CNT_W-1:0]          fill_next;
    t_rd_req                   rd_req;
    logic [SAMPLE_WIDTH-1:0]   rd_data;
    logic [SCALE_W-1:0]        scale;
    logic                      pipe_valid;
    logic signed [QUANT_W-1:0] pipe_quant;
    logic [COL_W-1:0]          pipe_col;
    logic                      pipe_last;

    always_comb begin
        sample_mag = magnitude(i_sample);
        run_max    = (sample_mag > r_absmax) ? sample_mag : r_absmax;
        fill_next  = r_fill + CNT_W'(1);
        in_acc     = i_valid && fill_en;
        row_close  = in_acc && (i_last_in_row || fill_next == CNT_W'(MAX_COLS));
        advance    = !r_out_valid || !i_stall;
        out_done   = r_out_valid && !i_stall && r_out_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (row_close) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_done) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_comb begin
        fill_en  = 1'b0;
        drain_en = 1'b0;
        case (r_state)
            ST_FILL:  fill_en  = 1'b1;
            ST_DRAIN: drain_en = 1'b1;
            default: begin
                fill_en  = 1'b0;
                drain_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_req.valid = drain_en && (r_rd_cnt < r_row_len);
        rd_req.col   = r_rd_cnt[COL_W-1:0];
        rd_req.last  = (r_rd_cnt == r_row_len - CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill      <= '0;
            r_row_len   <= '0;
            r_rd_cnt    <= '0;
            r_absmax    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (row_close) begin
                    r_fill    <= '0;
                    r_absmax  <= '0;
                    r_row_len <= fill_next;
                    r_rd_cnt  <= '0;
                end else begin
                    r_fill   <= fill_next;
                    r_absmax <= run_max;
                end
            end
            if (rd_req.valid && advance) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            if (advance) begin
                r_out_valid <= pipe_valid;
            end
        end
    end

    // floor absmax at 1 so an all-zero row still divides cleanly
    always_ff @(posedge i_clk) begin
        if (row_close) begin
            r_amax <= (run_max == '0) ? MAG_W'(1) : run_max;
        end
        if (advance) begin
            r_out_quant <= pipe_quant;
            r_out_scale <= scale;
            r_out_col   <= pipe_col;
            r_out_last  <= pipe_last;
        end
    end

    paq_row_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_fill[COL_W-1:0]),
        .i_wdata (i_sample),
        .i_re    (advance),
        .i_raddr (rd_req.col),
        .o_rdata (rd_data)
    );

    paq_scale u_scale (
        .i_clk   (i_clk),
        .i_amax  (r_amax),
        .o_scale (scale)
    );

    paq_quant_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (rd_req),
        .i_rdata   (rd_data),
        .i_amax    (r_amax),
        .o_valid   (pipe_valid),
        .o_quant   (pipe_quant),
        .o_col     (pipe_col),
        .o_last    (pipe_last)
    );

    assign o_stall       = !fill_en;
    assign o_valid       = r_out_valid;
    assign o_quant_value = r_out_quant;
    assign o_row_scale   = r_out_scale;
    assign o_column      = r_out_col;
    assign o_last_of_row = r_out_last;

    a_out_only_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == ST_DRAIN)
        else $error("result item outside of row drain");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= r_row_len)
        else $error("buffer read issued beyond row length");

    a_row_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done |=> !r_out_valid)
        else $error("result item left over after last of row");

    a_fill_idle_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> r_fill == '0 && r_absmax == '0)
        else $error("row fill state not cleared during drain");

endmodule

// ===== tb/sv/per_row_absmax_int8_quantizer_tb.sv =====
// Self-checking testbench for per_row_absmax_int8_quantizer: directed rows from a
// table, then random rows under several idle/stall mixes and a long output
// hold-off, checked by a row predictor. Depends on paq_pkg and the RTL of the block.
module per_row_absmax_int8_quantizer_tb;

    localparam int SW          = paq_pkg::SAMPLE_WIDTH;
    localparam int QW          = paq_pkg::QUANT_W;
    localparam int SCW         = paq_pkg::SCALE_W;
    localparam int CW          = paq_pkg::COL_W;
    localparam int NCOLS       = paq_pkg::MAX_COLS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int N_DIRECTED  = 20;
    localparam int PHASE_ITEMS = 95;
    localparam int PRESS_ITEMS = 40;

    typedef struct packed {
        logic signed [QW-1:0] quant;
        logic [SCW-1:0]       scale;
        logic [CW-1:0]        col;
        logic                 last;
    } quant_result_t;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last;
        logic                 typed;
        logic signed [QW-1:0] quant;
        logic [SCW-1:0]       scale;
    } directed_item_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic signed [SW-1:0] i_sample;
    logic                 i_last_in_row;
    logic                 o_stall;
    logic                 o_valid;
    logic signed [QW-1:0] o_quant_value;
    logic [SCW-1:0]       o_row_scale;
    logic [CW-1:0]        o_column;
    logic                 o_last_of_row;
    logic                 i_stall;

    per_row_absmax_int8_quantizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_sample      (i_sample),
        .i_last_in_row (i_last_in_row),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_quant_value (o_quant_value),
        .o_row_scale   (o_row_scale),
        .o_column      (o_column),
        .o_last_of_row (o_last_of_row),
        .i_stall       (i_stall)
    );

    // single-sample rows carry their result; the rest go through the predictor
    directed_item_t directed_tbl [N_DIRECTED] = '{
        '{0,      1'b1, 1'b1, 0,    516},
        '{32767,  1'b1, 1'b1, 127,  16908804},
        '{-32768, 1'b1, 1'b1, -127, 16909320},
        '{1,      1'b1, 1'b1, 127,  516},
        '{-1,     1'b1, 1'b1, -127, 516},
        '{-32768, 1'b0, 1'b0, 0,    0},
        '{32767,  1'b0, 1'b0, 0,    0},
        '{0,      1'b1, 1'b0, 0,    0},
        '{254,    1'b0, 1'b0, 0,    0},
        '{1,      1'b0, 1'b0, 0,    0},
        '{-1,     1'b0, 1'b0, 0,    0},
        '{3,      1'b1, 1'b0, 0,    0},
        '{0,      1'b0, 1'b0, 0,    0},
        '{0,      1'b1, 1'b0, 0,    0},
        '{-32767, 1'b0, 1'b0, 0,    0},
        '{-32768, 1'b0, 1'b0, 0,    0},
        '{16384,  1'b1, 1'b0, 0,    0},
        '{12345,  1'b0, 1'b0, 0,    0},
        '{-4567,  1'b0, 1'b0, 0,    0},
        '{-12345, 1'b1, 1'b0, 0,    0}
    };

    // predictor state
    logic [SW-1:0]   row_mem [NCOLS];
    longint unsigned row_absmax;
    int              row_fill;

    quant_result_t   pending_results [$];
    int              mismatch_count;
    int              cycle_count;
    int              items_sent;
    int              send_idle_pct;
    int              stall_pct;
    bit              hold_req;

    function automatic longint unsigned magnitude_of(logic [SW-1:0] raw);
        longint unsigned u;
        u = raw;
        return raw[SW-1] ? ((64'd1 << SW) - u) : u;
    endfunction

    // update the row state; on row close queue one result per buffered sample
    function automatic void absorb_sample(logic [SW-1:0] raw, logic last, logic typed,
                                          logic signed [QW-1:0] tq, logic [SCW-1:0] ts);
        longint unsigned amax;
        longint unsigned scale;
        longint unsigned mag;
        longint unsigned qm;
        quant_result_t   res;
        row_mem[row_fill] = raw;
        row_fill++;
        mag = magnitude_of(raw);
        if (mag > row_absmax) begin
            row_absmax = mag;
        end
        if (!last && row_fill < NCOLS) begin
            return;
        end
        amax  = (row_absmax == 0) ? 1 : row_absmax;
        scale = ((amax << 16) * 2 + 127) / 254;
        if (typed) begin
            res.quant = tq;
            res.scale = ts;
            res.col   = '0;
            res.last  = 1'b1;
            pending_results = {pending_results, res};
        end else begin
            for (int k = 0; k < row_fill; k++) begin
                qm = (2 * magnitude_of(row_mem[k]) * 127 + amax) / (2 * amax);
                if (qm > 127) begin
                    qm = 127;
                end
                res.quant = row_mem[k][SW-1] ? QW'(-qm) : QW'(qm);
                res.scale = SCW'(scale);
                res.col   = CW'(k);
                res.last  = (k == row_fill - 1);
                pending_results = {pending_results, res};
            end
        end
        row_absmax = 0;
        row_fill   = 0;
    endfunction

    // entered and left at a falling edge
    task automatic offer_item(logic signed [SW-1:0] s, logic l, logic typed,
                              logic signed [QW-1:0] tq, logic [SCW-1:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= s;
        i_last_in_row <= l;
        do @(posedge i_clk); while (o_stall);
        absorb_sample(s, l, typed, tq, ts);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_row(bit long_row, int max_len);
        int                   len;
        int                   style;
        bit                   noise;
        logic signed [SW-1:0] s;
        logic                 l;
        len   = $urandom_range(max_len, 1);
        noise = ($urandom_range(9) == 0);
        style = $urandom_range(5);
        if (long_row || $urandom_range(99) < 8) begin
            len = $urandom_range(90, 65);
        end else if ($urandom_range(99) < 12) begin
            len = $urandom_range(64, 13);
        end
        for (int k = 0; k < len; k++) begin
            case (style)
                0: s = SW'($urandom);
                1: s = SW'($urandom_range(600) - 300);
                2: begin
                    case ($urandom_range(4))
                        0: s = {1'b1, {(SW-1){1'b0}}};
                        1: s = {1'b0, {(SW-1){1'b1}}};
                        2: s = '0;
                        3: s = 1;
                        default: s = '1;
                    endcase
                end
                3: s = '0;
                // odd values against an absmax of 254 land on exact halves
                4: s = (k == 0) ? SW'(254) : SW'($urandom_range(508) - 254);
                default: s = (k == 0) ? {1'b1, {(SW-1){1'b0}}} : SW'($urandom);
            endcase
            l = noise ? ($urandom_range(3) == 0) : (k == len - 1);
            offer_item(s, l, 1'b0, '0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall, or one long hold-off when asked
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        quant_result_t got;
        quant_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_quant_value, o_row_scale, o_column, o_last_of_row};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: q=%0d scale=%0d col=%0d last=%0b",
                             got.quant, got.scale, got.col, got.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp q=%0d scale=%0d col=%0d last=%0b, %s",
                                 want.quant, want.scale, want.col, want.last,
                                 $sformatf("got q=%0d scale=%0d col=%0d last=%0b",
                                           got.quant, got.scale, got.col, got.last));
                    end
                end
            end
        end
    end

    initial begin
        int start;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_sample       = '0;
        i_last_in_row  = 1'b0;
        row_absmax     = 0;
        row_fill       = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_req       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[i]) begin
            offer_item(directed_tbl[i].sample, directed_tbl[i].last, directed_tbl[i].typed,
                       directed_tbl[i].quant, directed_tbl[i].scale);
        end

        // no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 33) : 0;
            stall_pct     = (ph == 2 || ph == 3) ? ((ph == 2) ? 61 : 33) : 0;
            start         = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                send_random_row(ph == 0 && items_sent == start, 12);
            end
        end

        // hold the output off while mostly short rows keep coming, so the block backs up
        send_idle_pct = 0;
        stall_pct     = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        start = items_sent;
        while (items_sent - start < PRESS_ITEMS) begin
            send_random_row(1'b0, 4);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/paq_pkg.sv
rtl/core/paq_row_ram.sv
rtl/core/paq_scale.sv
rtl/core/paq_quant_pipe.sv
rtl/core/per_row_absmax_int8_quantizer.sv
tb/sv/per_row_absmax_int8_quantizer_tb.sv
